>>> hdl/linked_list_queue_manager_core_defines.svh
// Assertion macros used by the queue manager sequencer, llq_ctrl.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef LINKED_LIST_QUEUE_MANAGER_CORE_DEFINES_SVH
`define LINKED_LIST_QUEUE_MANAGER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define LLQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define LLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/llq_pkg.sv
// Shared types and codes for the linked list queue manager.
// No dependencies; used by the interfaces, llq_ctrl, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package llq_pkg;

  localparam int NODE_W = 6;
  localparam int NODES  = 1 << NODE_W;
  localparam int KIND_W = 3;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [KIND_W-1:0] kind_t;

  // request kinds
  localparam kind_t KIND_RESET    = 3'd0;
  localparam kind_t KIND_ADD_HEAD = 3'd1;
  localparam kind_t KIND_ADD_TAIL = 3'd2;
  localparam kind_t KIND_REM_HEAD = 3'd3;
  localparam kind_t KIND_REM_TAIL = 3'd4;
  localparam kind_t KIND_UNLINK   = 3'd5;
  localparam kind_t KIND_QUERY    = 3'd6;

  typedef struct packed {
    kind_t kind;
    node_t queue_node;
    node_t entry_node;
  } req_t;

  typedef struct packed {
    node_t out_node;
    logic  queue_empty;
    logic  status;
  } rsp_t;

  // link memory port groups
  typedef struct packed {
    logic  we;
    node_t addr;
    node_t data;
  } ram_wr_t;

  typedef struct packed {
    logic  re;
    node_t addr;
  } ram_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MID,
    ST_LAST
  } state_t;

endpackage

`default_nettype wire

>>> hdl/llq_req_if.sv
// Request channel: valid/ready handshake carrying one queue request.
// Depends on llq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface llq_req_if;
  logic          valid;
  logic          ready;
  llq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/llq_rsp_if.sv
// Response channel: valid/ready handshake carrying one queue result.
// Depends on llq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface llq_rsp_if;
  logic          valid;
  logic          ready;
  llq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/llq_link_ram.sv
// Link memory: one write and one registered read port per cycle.
// Entries never written since reset read back as their own address.
`timescale 1ns / 1ps
`default_nettype none

module llq_link_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [AW-1:0] rdata
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // written flags: a clear flag means self-linked
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= vld[raddr] ? mem[raddr] : raddr;
    end
  end

endmodule

`default_nettype wire

>>> hdl/llq_ctrl.sv
// Request sequencer: reads, relinks and writes back the two link memories,
// and holds the result register. Depends on llq_pkg, the channel interfaces and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_queue_manager_core_defines.svh"

module llq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  llq_req_if.sink               req,
  llq_rsp_if.source             rsp,
  output llq_pkg::ram_wr_t      nwr,
  output llq_pkg::ram_wr_t      pwr,
  output llq_pkg::ram_rd_t      nrd,
  output llq_pkg::ram_rd_t      prd,
  input  wire llq_pkg::node_t   nrdata,
  input  wire llq_pkg::node_t   prdata
);

  llq_pkg::state_t state, state_next;
  llq_pkg::req_t   cur;
  llq_pkg::node_t  a_next;   // first-cycle read of next memory
  llq_pkg::node_t  a_prev;   // first-cycle read of prev memory
  logic            out_valid;
  llq_pkg::rsp_t   out_data;
  llq_pkg::rsp_t   res;
  logic            accept;

  assign req.ready = (state == llq_pkg::ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      llq_pkg::ST_IDLE: if (accept) state_next = llq_pkg::ST_MID;
      llq_pkg::ST_MID:  state_next = llq_pkg::ST_LAST;
      llq_pkg::ST_LAST: state_next = llq_pkg::ST_IDLE;
      default:          state_next = llq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memory accesses and result per state
  always_comb begin
    llq_pkg::node_t q;
    llq_pkg::node_t e;
    llq_pkg::node_t fin;
    q   = cur.queue_node;
    e   = cur.entry_node;
    fin = a_next;
    nwr = '0;
    pwr = '0;
    nrd = '0;
    prd = '0;
    res = '{out_node: e, queue_empty: 1'b0, status: 1'b0};
    unique case (state)
      llq_pkg::ST_IDLE: begin
        // first reads: links of the entry for unlink, else of the sentinel
        nrd.re   = accept;
        prd.re   = accept;
        nrd.addr = (req.data.kind == llq_pkg::KIND_UNLINK) ?
                   req.data.entry_node : req.data.queue_node;
        prd.addr = nrd.addr;
      end
      llq_pkg::ST_MID: begin
        unique case (cur.kind)
          llq_pkg::KIND_RESET: begin
            nwr = '{we: 1'b1, addr: e, data: e};
            pwr = '{we: 1'b1, addr: e, data: e};
          end
          llq_pkg::KIND_ADD_HEAD: begin
            nwr = '{we: 1'b1, addr: e, data: nrdata};
            pwr = '{we: 1'b1, addr: e, data: q};
          end
          llq_pkg::KIND_ADD_TAIL: begin
            nwr = '{we: 1'b1, addr: e, data: q};
            pwr = '{we: 1'b1, addr: e, data: prdata};
          end
          llq_pkg::KIND_REM_HEAD: nrd = '{re: 1'b1, addr: nrdata};
          llq_pkg::KIND_REM_TAIL: prd = '{re: 1'b1, addr: prdata};
          llq_pkg::KIND_UNLINK: begin
            // old sentinel link is fetched while the neighbors are bridged
            nrd = '{re: 1'b1, addr: q};
            if (nrdata != e) begin
              nwr = '{we: 1'b1, addr: prdata, data: nrdata};
              pwr = '{we: 1'b1, addr: nrdata, data: prdata};
            end
          end
          default: ;
        endcase
      end
      llq_pkg::ST_LAST: begin
        unique case (cur.kind)
          llq_pkg::KIND_RESET: begin
            res.queue_empty = (q == e) || (a_next == q);
          end
          llq_pkg::KIND_ADD_HEAD: begin
            nwr = '{we: 1'b1, addr: q, data: e};
            pwr = '{we: 1'b1, addr: a_next, data: e};
            res.queue_empty = (e == q);
          end
          llq_pkg::KIND_ADD_TAIL: begin
            nwr = '{we: 1'b1, addr: a_prev, data: e};
            pwr = '{we: 1'b1, addr: q, data: e};
            if (a_prev == q) begin
              fin = e;
            end else if (e == q) begin
              fin = q;
            end
            res.queue_empty = (fin == q);
          end
          llq_pkg::KIND_REM_HEAD: begin
            if (a_next == q) begin
              res = '{out_node: q, queue_empty: 1'b1, status: 1'b1};
            end else begin
              nwr = '{we: 1'b1, addr: q, data: nrdata};
              pwr = '{we: 1'b1, addr: nrdata, data: q};
              res = '{out_node: a_next, queue_empty: (nrdata == q), status: 1'b0};
            end
          end
          llq_pkg::KIND_REM_TAIL: begin
            if (a_next == q) begin
              res = '{out_node: q, queue_empty: 1'b1, status: 1'b1};
            end else begin
              nwr = '{we: 1'b1, addr: prdata, data: q};
              pwr = '{we: 1'b1, addr: q, data: prdata};
              res = '{out_node: a_prev, queue_empty: (prdata == q), status: 1'b0};
            end
          end
          llq_pkg::KIND_UNLINK: begin
            // here a_next/a_prev are the entry's links, nrdata the old next[q]
            fin = nrdata;
            if (a_next == e) begin
              res.status = 1'b1;
            end else begin
              nwr = '{we: 1'b1, addr: e, data: e};
              pwr = '{we: 1'b1, addr: e, data: e};
              if (q == e) begin
                fin = q;
              end else if (q == a_prev) begin
                fin = a_next;
              end
            end
            res.queue_empty = (fin == q);
          end
          default: begin
            res.queue_empty = (a_next == q);
          end
        endcase
      end
      default: ;
    endcase
  end

  // request capture and first-read hold
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req.data;
    end
    if (state == llq_pkg::ST_MID) begin
      a_next <= nrdata;
      a_prev <= prdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == llq_pkg::ST_LAST) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == llq_pkg::ST_LAST) begin
      out_data <= res;
    end
  end

  `LLQ_ASSERT_NEXT(a_accept_starts, accept, state == llq_pkg::ST_MID, "accept did not start sequence")
  `LLQ_ASSERT_NEXT(a_mid_to_last, state == llq_pkg::ST_MID, state == llq_pkg::ST_LAST, "sequence stalled")
  `LLQ_ASSERT_NOW(a_last_free, state == llq_pkg::ST_LAST, !out_valid, "result register busy at finish")
  `LLQ_ASSERT_NOW(a_idle_no_wr, state == llq_pkg::ST_IDLE, !nwr.we && !pwr.we, "link write while idle")

endmodule

`default_nettype wire

>>> hdl/linked_list_queue_manager_core.sv
// Circular doubly linked queue manager, top level.
// Channels: req (sink) takes {kind, queue_node, entry_node}; rsp (source)
//   returns {out_node, queue_empty, status}, both valid/ready, a transfer
//   happening on a clock edge with valid and ready high.
// Each request steps through the sequencer states: the transfer cycle reads both link
//   memories, ST_MID reads again or does the first link writes, ST_LAST does
//   the last writes and loads the result register. The result is valid in
//   the cycle after ST_LAST, and no new request is taken until the sequencer
//   is back in idle, set by the one read and one write port of each link memory.
// req.ready is high only while the sequencer is idle and the result register
//   is empty or being drained in that cycle; a stalled receiver simply holds
//   the result and blocks the next request.
// Reset (rst, synchronous) clears the per-entry written flags in the link
//   memories, so every node reads as self-linked right after reset with no
//   clearing pass, and drops any pending result.
// Depends on llq_pkg, llq_req_if, llq_rsp_if, llq_link_ram and llq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module linked_list_queue_manager_core (
  input  wire logic clk,
  input  wire logic rst,
  llq_req_if.sink   req,
  llq_rsp_if.source rsp
);

  llq_pkg::ram_wr_t nwr, pwr;
  llq_pkg::ram_rd_t nrd, prd;
  llq_pkg::node_t   nrdata, prdata;

  // sequencer and result register
  llq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .nwr    (nwr),
    .pwr    (pwr),
    .nrd    (nrd),
    .prd    (prd),
    .nrdata (nrdata),
    .prdata (prdata)
  );

  // next links
  llq_link_ram #(
    .DEPTH (llq_pkg::NODES),
    .AW    (llq_pkg::NODE_W)
  ) u_next_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (nwr.we),
    .waddr (nwr.addr),
    .wdata (nwr.data),
    .re    (nrd.re),
    .raddr (nrd.addr),
    .rdata (nrdata)
  );

  // prev links
  llq_link_ram #(
    .DEPTH (llq_pkg::NODES),
    .AW    (llq_pkg::NODE_W)
  ) u_prev_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (pwr.we),
    .waddr (pwr.addr),
    .wdata (pwr.data),
    .re    (prd.re),
    .raddr (prd.addr),
    .rdata (prdata)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for linked_list_queue_manager_core: a link table model
// predicts every response, with directed and random request traffic.
// Depends on llq_pkg, llq_req_if, llq_rsp_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import llq_pkg::*;

  localparam int    CLK_HALF    = 5;
  localparam int    RESET_LEN   = 5;
  localparam int    HOLD_CYCLES = 300;
  localparam int    DRAIN_WAIT  = 10;
  localparam int    CYCLE_LIMIT = 200000;
  localparam int    REPORT_MAX  = 10;
  localparam kind_t KIND_SPARE  = 3'd7;   // unused code, behaves as a query
  localparam logic  STATUS_OK   = 1'b0;
  localparam logic  STATUS_ERR  = 1'b1;

  logic clk = 1'b0;
  logic rst;

  llq_req_if req_ch ();
  llq_rsp_if rsp_ch ();

  linked_list_queue_manager_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Model link table and responses still owed by the block
  node_t link_next [NODES];
  node_t link_prev [NODES];
  rsp_t  pending_results [$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  int    burst_left     = 0;
  bit    hold_rsp       = 1'b0;
  node_t heads [4];

  function automatic void clear_links();
    for (int i = 0; i < NODES; i++) begin
      link_next[i] = node_t'(i);
      link_prev[i] = node_t'(i);
    end
  endfunction

  // Apply one request to the model table, in the block's write order
  function automatic rsp_t predict_queue_op(req_t r);
    rsp_t  res;
    node_t q;
    node_t e;
    node_t t;
    q = r.queue_node;
    e = r.entry_node;
    res.out_node = e;
    res.status   = STATUS_OK;
    // every 6-bit index lies inside the 64-node pool, so no range check here
    case (r.kind)
      KIND_RESET: begin
        link_next[e] = e;
        link_prev[e] = e;
      end
      KIND_ADD_HEAD: begin
        link_next[e] = link_next[q];
        link_prev[e] = q;
        link_prev[link_next[e]] = e;
        link_next[q] = e;
      end
      KIND_ADD_TAIL: begin
        link_next[e] = q;
        link_prev[e] = link_prev[q];
        link_next[link_prev[e]] = e;
        link_prev[q] = e;
      end
      KIND_REM_HEAD: begin
        if (link_next[q] == q) begin
          res.out_node = q;
          res.status   = STATUS_ERR;
        end else begin
          t = link_next[q];
          link_prev[link_next[t]] = q;
          link_next[q] = link_next[t];
          res.out_node = t;
        end
      end
      KIND_REM_TAIL: begin
        if (link_next[q] == q) begin
          res.out_node = q;
          res.status   = STATUS_ERR;
        end else begin
          t = link_prev[q];
          link_next[link_prev[t]] = q;
          link_prev[q] = link_prev[t];
          res.out_node = t;
        end
      end
      KIND_UNLINK: begin
        if (link_next[e] == e) begin
          res.status = STATUS_ERR;
        end else begin
          link_next[link_prev[e]] = link_next[e];
          link_prev[link_next[e]] = link_prev[e];
          link_next[e] = e;
          link_prev[e] = e;
        end
      end
      default: ;
    endcase
    res.queue_empty = (link_next[q] == q);
    return res;
  endfunction

  function automatic bit is_free(node_t n);
    return link_next[n] == n;
  endfunction

  function automatic bit is_head(node_t n);
    foreach (heads[i]) if (heads[i] == n) return 1'b1;
    return 1'b0;
  endfunction

  // Random non-sentinel node that is free (or linked); found=0 if none turned up
  function automatic node_t pick_node(bit want_free, output bit found);
    node_t n;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      n = node_t'($urandom_range(0, NODES - 1));
      if (!is_head(n) && is_free(n) == want_free) begin
        found = 1'b1;
        return n;
      end
    end
    return n;
  endfunction

  // Offer one request in bursts with random gaps; predict it on transfer
  task automatic send_req(input kind_t k, input node_t q, input node_t e,
                          output rsp_t predicted);
    req_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    r.kind       = k;
    r.queue_node = q;
    r.entry_node = e;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = predict_queue_op(r);
    pending_results.push_back(predicted);
  endtask

  task automatic report_mismatch(string field, int want, int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, field, want, got);
  endtask

  // Empty-queue behavior: removals, query, spare code and unlink of a lone node
  task automatic test_empty_queue();
    rsp_t p;
    send_req(KIND_QUERY,    6'd0,  6'd63, p);
    send_req(KIND_REM_HEAD, 6'd63, 6'd0,  p);
    send_req(KIND_REM_TAIL, 6'd0,  6'd63, p);
    send_req(KIND_UNLINK,   6'd0,  6'd63, p);
    send_req(KIND_SPARE,    6'd0,  6'd5,  p);
  endtask

  // Head and tail ordering, unlink of the front node, resets of removed nodes
  task automatic test_head_tail_order();
    rsp_t p;
    send_req(KIND_ADD_HEAD, 6'd0, 6'd63, p);
    send_req(KIND_ADD_TAIL, 6'd0, 6'd1,  p);
    send_req(KIND_ADD_HEAD, 6'd0, 6'd2,  p);
    send_req(KIND_QUERY,    6'd0, 6'd0,  p);
    send_req(KIND_REM_HEAD, 6'd0, 6'd0,  p);
    send_req(KIND_RESET,    6'd0, p.out_node, p);
    send_req(KIND_UNLINK,   6'd0, 6'd63, p);
    send_req(KIND_REM_TAIL, 6'd0, 6'd0,  p);
    send_req(KIND_RESET,    6'd0, p.out_node, p);
    send_req(KIND_SPARE,    6'd0, 6'd0,  p);
  endtask

  // Inserts without checks: entry equal to sentinel, entry already queued
  task automatic test_special_inserts();
    rsp_t p;
    send_req(KIND_ADD_TAIL, 6'd63, 6'd63, p);
    send_req(KIND_QUERY,    6'd63, 6'd63, p);
    send_req(KIND_RESET,    6'd0,  6'd63, p);
    send_req(KIND_ADD_HEAD, 6'd10, 6'd20, p);
    send_req(KIND_ADD_HEAD, 6'd11, 6'd20, p);
    send_req(KIND_REM_TAIL, 6'd10, 6'd20, p);
    send_req(KIND_RESET,    6'd0,  6'd20, p);
    send_req(KIND_RESET,    6'd0,  6'd10, p);
    send_req(KIND_RESET,    6'd0,  6'd11, p);
  endtask

  // Mostly well-formed queue traffic on four sentinels, with some raw noise
  task automatic run_traffic(int count, int noise_pct);
    rsp_t  p;
    node_t s;
    node_t n;
    bit    found;
    int    pick;
    int    sent;
    foreach (heads[i]) heads[i] = node_t'($urandom_range(0, NODES - 1));
    sent = 0;
    while (sent < count) begin
      s    = heads[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < noise_pct) begin
        send_req(kind_t'($urandom_range(0, 7)), node_t'($urandom_range(0, NODES - 1)),
                 node_t'($urandom_range(0, NODES - 1)), p);
      end else if (pick < 40) begin
        n = pick_node(1'b1, found);
        if (found)
          send_req(pick[0] ? KIND_ADD_HEAD : KIND_ADD_TAIL, s, n, p);
        else
          send_req(KIND_REM_HEAD, s, node_t'($urandom), p);
      end else if (pick < 65) begin
        send_req(pick[0] ? KIND_REM_HEAD : KIND_REM_TAIL, s, node_t'($urandom), p);
        // removed nodes keep stale links; free them before reuse
        if (p.status == STATUS_OK) begin
          send_req(KIND_RESET, node_t'($urandom), p.out_node, p);
          sent++;
        end
      end else if (pick < 77) begin
        n = pick_node(1'b0, found);
        send_req(KIND_UNLINK, s, n, p);
      end else if (pick < 88) begin
        send_req(pick[0] ? KIND_QUERY : KIND_SPARE, s, node_t'($urandom), p);
      end else if (pick < 94) begin
        n = pick_node(1'b1, found);
        send_req(KIND_UNLINK, s, n, p);
      end else begin
        n = pick_node(1'b1, found);
        send_req(KIND_RESET, s, n, p);
      end
      sent++;
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 7; round++)
      run_traffic(200, (round == 6) ? 40 : 10);
  endtask

  // Receiver holds off long enough that the result register fills and
  // request transfers stall
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    run_traffic(30, 10);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = rsp_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, out_node", -1, got.out_node);
      end else begin
        want = pending_results.pop_front();
        if (got.out_node !== want.out_node)
          report_mismatch("out_node", want.out_node, got.out_node);
        if (got.queue_empty !== want.queue_empty)
          report_mismatch("queue_empty", want.queue_empty, got.queue_empty);
        if (got.status !== want.status)
          report_mismatch("status", want.status, got.status);
      end
    end
  end

  // Receiver ready pattern, plus one long hold-off on request
  initial begin : rsp_pacer
    logic [7:0] stall_mask;
    int         phase;
    rsp_ch.ready = 1'b0;
    stall_mask   = '0;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        if (phase % 64 == 0) begin
          stall_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
          if (stall_mask == 8'hff) stall_mask = 8'hfe;
        end
        rsp_ch.ready <= ~stall_mask[phase % 8];
        phase++;
      end
    end
  end

  // Run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL linked_list_queue_manager_core");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    clear_links();
    repeat (RESET_LEN) @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_head_tail_order();
    test_special_inserts();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS linked_list_queue_manager_core");
    end else begin
      $display("FAIL linked_list_queue_manager_core");
    end
    $finish;
  end

endmodule
